// ----- sv/peak_level_vad_hysteresis_top_assert.svh -----
// Assertion macros for the peak-level voice activity detector.
// Used by the detector core; no other dependencies.
`ifndef PEAK_LEVEL_VAD_HYSTERESIS_TOP_ASSERT_SVH
`define PEAK_LEVEL_VAD_HYSTERESIS_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define VADH_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define VADH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/vadh_pkg.sv -----
// Types and constants for the peak-level voice activity detector.
// No dependencies.
package vadh_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int THRESH_BITS = 16;
  localparam int NEED_BITS   = 8;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_START  = 2'd1,
    OP_STOP   = 2'd2,
    OP_UNUSED = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_START = 2'd1,
    EV_END   = 2'd2
  } vad_event_t;

  localparam logic [CFG_IDX_BITS-1:0] CFG_STEREO_MODE    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_VAD_ENABLE     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPEECH_THRESH  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SILENCE_THRESH = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPEECH_NEEDED  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SILENCE_NEEDED = 3'd5;

  typedef struct packed {
    logic [1:0]                    opcode;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          frame_last;
  } item_t;

  typedef struct packed {
    logic                          sample_valid;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          frame_end;
    logic [1:0]                    vad_event;
    logic                          speaking;
  } result_t;

  typedef struct packed {
    logic                   stereo_mode;
    logic                   vad_enable;
    logic [THRESH_BITS-1:0] speech_threshold;
    logic [THRESH_BITS-1:0] silence_threshold;
    logic [NEED_BITS-1:0]   speech_frames_needed;
    logic [NEED_BITS-1:0]   silence_frames_needed;
  } cfg_t;

endpackage

// ----- sv/vadh_core.sv -----
// Detector core: frame peak tracking, hysteresis counters and result forming.
// Depends on vadh_pkg and peak_level_vad_hysteresis_top_assert.svh.
`include "peak_level_vad_hysteresis_top_assert.svh"

module vadh_core import vadh_pkg::*; #(
  parameter int COUNT_BITS = 8
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    accept,
  input  item_t   item,
  input  cfg_t    cfg,
  output logic    push,
  output result_t res
);

  localparam int CMP_BITS = (COUNT_BITS > NEED_BITS) ? COUNT_BITS : NEED_BITS;

  logic                   running, running_next;
  logic [SAMPLE_BITS-1:0] frame_peak, frame_peak_next;
  logic [COUNT_BITS-1:0]  speech_count, speech_count_next;
  logic [COUNT_BITS-1:0]  silence_count, silence_count_next;
  logic                   speaking_flag, speaking_flag_next;
  logic                   channel_phase, channel_phase_next;

  logic                   is_left;
  logic                   pass;
  logic [SAMPLE_BITS-1:0] raw;
  logic [SAMPLE_BITS-1:0] mag;
  logic [SAMPLE_BITS-1:0] peak_upd;
  logic [COUNT_BITS-1:0]  sp_cnt;
  logic [COUNT_BITS-1:0]  si_cnt;
  logic [1:0]             event_code;

  assign raw      = item.sample;
  assign mag      = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
  assign is_left  = !cfg.stereo_mode || !channel_phase;
  assign pass     = is_left && !(cfg.stereo_mode && item.frame_last);
  assign peak_upd = (cfg.vad_enable && is_left && (mag > frame_peak)) ? mag : frame_peak;

  always_comb begin
    sp_cnt = speech_count;
    si_cnt = silence_count;
    if (THRESH_BITS'(peak_upd) >= cfg.speech_threshold) begin
      if (speech_count != {COUNT_BITS{1'b1}}) begin
        sp_cnt = speech_count + 1'b1;
      end
      si_cnt = '0;
    end else if (THRESH_BITS'(peak_upd) <= cfg.silence_threshold) begin
      if (silence_count != {COUNT_BITS{1'b1}}) begin
        si_cnt = silence_count + 1'b1;
      end
      sp_cnt = '0;
    end
  end

  always_comb begin
    running_next       = running;
    frame_peak_next    = frame_peak;
    speech_count_next  = speech_count;
    silence_count_next = silence_count;
    speaking_flag_next = speaking_flag;
    channel_phase_next = channel_phase;
    event_code         = EV_NONE;
    push               = 1'b0;
    res                = '0;
    if (accept) begin
      unique case (item.opcode)
        OP_START: begin
          running_next       = 1'b1;
          frame_peak_next    = '0;
          speech_count_next  = '0;
          silence_count_next = '0;
          speaking_flag_next = 1'b0;
          channel_phase_next = 1'b0;
        end
        OP_STOP: begin
          push               = speaking_flag && cfg.vad_enable;
          res.vad_event      = EV_END;
          running_next       = 1'b0;
          frame_peak_next    = '0;
          speech_count_next  = '0;
          silence_count_next = '0;
          speaking_flag_next = 1'b0;
          channel_phase_next = 1'b0;
        end
        OP_SAMPLE: begin
          if (running) begin
            frame_peak_next    = peak_upd;
            channel_phase_next = cfg.stereo_mode ? !channel_phase : channel_phase;
            if (item.frame_last) begin
              if (cfg.vad_enable) begin
                speech_count_next  = sp_cnt;
                silence_count_next = si_cnt;
                if (!speaking_flag && (CMP_BITS'(sp_cnt) >=
                                       CMP_BITS'(cfg.speech_frames_needed))) begin
                  speaking_flag_next = 1'b1;
                  event_code         = EV_START;
                end else if (speaking_flag && (CMP_BITS'(si_cnt) >=
                                               CMP_BITS'(cfg.silence_frames_needed))) begin
                  speaking_flag_next = 1'b0;
                  event_code         = EV_END;
                end
              end
              frame_peak_next    = '0;
              channel_phase_next = 1'b0;
            end
            push             = pass || item.frame_last;
            res.sample_valid = pass;
            res.sample_out   = pass ? item.sample : '0;
            res.frame_end    = item.frame_last;
            res.vad_event    = event_code;
            res.speaking     = speaking_flag_next;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running       <= 1'b0;
      frame_peak    <= '0;
      speech_count  <= '0;
      silence_count <= '0;
      speaking_flag <= 1'b0;
      channel_phase <= 1'b0;
    end else begin
      running       <= running_next;
      frame_peak    <= frame_peak_next;
      speech_count  <= speech_count_next;
      silence_count <= silence_count_next;
      speaking_flag <= speaking_flag_next;
      channel_phase <= channel_phase_next;
    end
  end

  `VADH_ASSERT_IMP(a_idle_silent, clk, rst, !running, !speaking_flag, "speaking while stopped")
  `VADH_ASSERT_IMP(a_start_speaks, clk, rst, push && (res.vad_event == EV_START),
                   res.speaking, "speech start without speaking flag")
  `VADH_ASSERT_NEXT(a_stop_clears, clk, rst, accept && (item.opcode == OP_STOP),
                    !running && (frame_peak == '0) && !channel_phase, "stop left state behind")

endmodule

// ----- sv/vadh_obuf.sv -----
// Two-entry result buffer: an output register with a skid register behind it.
// Depends on vadh_pkg.
module vadh_obuf import vadh_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t din,
  output logic    full,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  logic    head_valid;
  logic    skid_valid;
  result_t skid;
  logic    pop;

  assign pop          = head_valid && result_ready;
  assign full         = skid_valid;
  assign result_valid = head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid) begin
          result     <= skid;
          skid_valid <= push;
          skid       <= din;
        end else begin
          head_valid <= push;
          result     <= din;
        end
      end else if (push) begin
        if (!head_valid) begin
          head_valid <= 1'b1;
          result     <= din;
        end else begin
          skid_valid <= 1'b1;
          skid       <= din;
        end
      end
    end
  end

endmodule

// ----- sv/peak_level_vad_hysteresis_top.sv -----
// Top level of the peak-level voice activity detector with stereo pass-through.
// Depends on vadh_pkg, vadh_core and vadh_obuf.
//
//   Channel   Direction  Handshake                   Payload
//   item      in         item_valid / item_ready     item_t (opcode, sample, frame_last)
//   result    out        result_valid / result_ready result_t
//   config    in         cfg_we (no wait)            cfg_index, cfg_data
//
// One item is accepted per cycle while item_ready is high; its result, if any, is in
// the output register on the next cycle unless an earlier result still waits there,
// in which case it goes to the skid register. Input is taken while one result waits;
// item_ready drops only when both entries are occupied.
// Reset is synchronous; configuration returns to its defaults and detection stops.
module peak_level_vad_hysteresis_top import vadh_pkg::*; #(
  parameter int COUNT_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_ready,
  input  item_t                    item,
  output logic                     result_valid,
  input  logic                     result_ready,
  output result_t                  result,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  cfg_t    cfg;
  logic    accept;
  logic    push;
  logic    full;
  result_t res;

  assign item_ready = !full;
  assign accept     = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stereo_mode           <= 1'b0;
      cfg.vad_enable            <= 1'b1;
      cfg.speech_threshold      <= THRESH_BITS'(1200);
      cfg.silence_threshold     <= THRESH_BITS'(700);
      cfg.speech_frames_needed  <= NEED_BITS'(2);
      cfg.silence_frames_needed <= NEED_BITS'(12);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEREO_MODE:    cfg.stereo_mode           <= cfg_data[0];
        CFG_VAD_ENABLE:     cfg.vad_enable            <= cfg_data[0];
        CFG_SPEECH_THRESH:  cfg.speech_threshold      <= cfg_data[THRESH_BITS-1:0];
        CFG_SILENCE_THRESH: cfg.silence_threshold     <= cfg_data[THRESH_BITS-1:0];
        CFG_SPEECH_NEEDED:  cfg.speech_frames_needed  <= cfg_data[NEED_BITS-1:0];
        CFG_SILENCE_NEEDED: cfg.silence_frames_needed <= cfg_data[NEED_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  vadh_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .cfg    (cfg),
    .push   (push),
    .res    (res)
  );

  vadh_obuf u_obuf (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .din          (res),
    .full         (full),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for peak_level_vad_hysteresis_top: directed and random audio
// traffic with a clocked driver and monitor and a built-in detector prediction.
// Depends on vadh_pkg and the detector RTL.
module tb_top;
  import vadh_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] CFG_BAD_INDEX = 3'd7;
  localparam int STALL_CYCLES = 80;
  localparam logic [7:0] COUNT_MAX = 8'hFF;

  logic clk;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  peak_level_vad_hysteresis_top DUT (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  item_t items_to_send[$];
  result_t vad_results_due[$];
  int mismatches = 0;

  logic item_taken = 1'b0;
  logic result_taken = 1'b0;
  int tx_wait = 0;
  int rx_wait = 0;
  bit tx_gaps_on = 1'b1;
  bit rx_gaps_on = 1'b1;
  bit hold_req = 1'b0;
  logic rx_hold = 1'b0;

  cfg_t cur_cfg = '{stereo_mode: 1'b0, vad_enable: 1'b1, speech_threshold: 16'd1200,
                    silence_threshold: 16'd700, speech_frames_needed: 8'd2,
                    silence_frames_needed: 8'd12};
  logic run_flag = 1'b0;
  logic [15:0] peak_mag = '0;
  logic [7:0] speech_frames = '0;
  logic [7:0] silence_frames = '0;
  logic spk_flag = 1'b0;
  logic phase_right = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_vad_state();
    spk_flag = 1'b0;
    speech_frames = '0;
    silence_frames = '0;
    peak_mag = '0;
    phase_right = 1'b0;
  endfunction

  task automatic predict_vad(input item_t it, output bit has_res, output result_t res);
    logic [15:0] raw;
    logic [15:0] mag;
    bit left_ch;
    bit pass_on;
    vad_event_t ev;
    has_res = 1'b0;
    res = '0;
    case (it.opcode)
      OP_START: begin
        run_flag = 1'b1;
        clear_vad_state();
      end
      OP_STOP: begin
        if (spk_flag && cur_cfg.vad_enable) begin
          has_res = 1'b1;
          res.vad_event = EV_END;
        end
        run_flag = 1'b0;
        clear_vad_state();
      end
      OP_SAMPLE: begin
        if (run_flag) begin
          raw = it.sample;
          left_ch = !cur_cfg.stereo_mode || !phase_right;
          pass_on = left_ch && !(cur_cfg.stereo_mode && it.frame_last);
          ev = EV_NONE;
          if (cur_cfg.vad_enable && left_ch) begin
            mag = raw[15] ? (~raw + 16'd1) : raw;
            if (mag > peak_mag) peak_mag = mag;
          end
          if (cur_cfg.stereo_mode) phase_right = !phase_right;
          if (it.frame_last) begin
            if (cur_cfg.vad_enable) begin
              if (peak_mag >= cur_cfg.speech_threshold) begin
                if (speech_frames != COUNT_MAX) speech_frames = speech_frames + 8'd1;
                silence_frames = '0;
              end else if (peak_mag <= cur_cfg.silence_threshold) begin
                if (silence_frames != COUNT_MAX) silence_frames = silence_frames + 8'd1;
                speech_frames = '0;
              end
              if (!spk_flag && speech_frames >= cur_cfg.speech_frames_needed) begin
                spk_flag = 1'b1;
                ev = EV_START;
              end else if (spk_flag && silence_frames >= cur_cfg.silence_frames_needed) begin
                spk_flag = 1'b0;
                ev = EV_END;
              end
            end
            peak_mag = '0;
            phase_right = 1'b0;
          end
          if (pass_on || it.frame_last) begin
            has_res = 1'b1;
            res.sample_valid = pass_on;
            res.sample_out = pass_on ? raw : '0;
            res.frame_end = it.frame_last;
            res.vad_event = ev;
            res.speaking = spk_flag;
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    bit bad;
    if (vad_results_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result with none expected: valid=%0b smp=%0d end=%0b ev=%0d spk=%0b",
                 $time, got.sample_valid, got.sample_out, got.frame_end, got.vad_event,
                 got.speaking);
    end else begin
      want = vad_results_due.pop_front();
      bad = (got.sample_valid !== want.sample_valid) || (got.sample_out !== want.sample_out) ||
            (got.frame_end !== want.frame_end) || (got.vad_event !== want.vad_event) ||
            (got.speaking !== want.speaking);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result mismatch: want valid=%0b smp=%0d end=%0b ev=%0d spk=%0b,",
                   $time, want.sample_valid, want.sample_out, want.frame_end,
                   want.vad_event, want.speaking,
                   " got valid=%0b smp=%0d end=%0b ev=%0d spk=%0b",
                   got.sample_valid, got.sample_out, got.frame_end,
                   got.vad_event, got.speaking);
      end
    end
  endtask

  always @(posedge clk) begin : monitor
    bit has_res;
    result_t res;
    item_taken <= !rst && item_valid && item_ready;
    result_taken <= !rst && result_valid && result_ready;
    if (!rst) begin
      if (result_valid && result_ready) check_result(result);
      if (item_valid && item_ready) begin
        predict_vad(item, has_res, res);
        if (has_res) vad_results_due.push_back(res);
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_taken) begin
      if (item_valid) tx_wait = tx_gaps_on ? $urandom_range(5, 0) : 0;
      if (tx_wait == 0 && items_to_send.size() != 0) begin
        item <= items_to_send.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
        if (tx_wait != 0) tx_wait--;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_taken) rx_wait = rx_gaps_on ? $urandom_range(5, 0) : 0;
      if (rx_hold) begin
        result_ready <= 1'b0;
      end else if (rx_wait != 0) begin
        result_ready <= 1'b0;
        rx_wait--;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  initial begin
    wait (hold_req);
    @(negedge clk);
    rx_hold <= 1'b1;
    repeat (STALL_CYCLES) @(negedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic void queue_item(input opcode_t op, input logic [15:0] smp, input bit last);
    item_t t;
    t.opcode = op;
    t.sample = smp;
    t.frame_last = last;
    items_to_send.push_back(t);
  endfunction

  function automatic logic [15:0] random_sample();
    return 16'($urandom_range(65535, 0));
  endfunction

  function automatic void queue_cmd(input opcode_t op);
    queue_item(op, random_sample(), 1'($urandom_range(1, 0)));
  endfunction

  // Kinds: 0 loud, 1 quiet, 2 between the thresholds, 3 anything.
  function automatic logic [15:0] level_sample(input int kind);
    int lo;
    int hi;
    int mag;
    lo = 0;
    hi = 32768;
    if (kind == 0) lo = cur_cfg.speech_threshold;
    if (kind == 1) hi = cur_cfg.silence_threshold;
    if (kind == 2) begin
      lo = cur_cfg.silence_threshold + 1;
      hi = cur_cfg.speech_threshold - 1;
    end
    if (hi > 32768) hi = 32768;
    if (lo > hi) begin
      lo = 0;
      hi = 32768;
    end
    mag = $urandom_range(hi, lo);
    if (mag == 32768) return 16'h8000;
    return $urandom_range(1, 0) ? 16'(-mag) : 16'(mag);
  endfunction

  task automatic queue_session(input int n_items);
    int done;
    int flen;
    int kind;
    int r;
    done = 0;
    queue_cmd(OP_START);
    while (done < n_items) begin
      r = $urandom_range(99, 0);
      if (r < 5) begin
        queue_cmd(OP_STOP);
        repeat ($urandom_range(2, 0))
          queue_item(OP_SAMPLE, random_sample(), 1'($urandom_range(1, 0)));
        queue_cmd(OP_START);
        done += 2;
      end else if (r < 8) begin
        queue_cmd(OP_UNUSED);
      end else if (r < 10) begin
        queue_cmd(OP_START);
        done++;
      end else if (r < 14) begin
        flen = $urandom_range(3, 1);
        for (int k = 0; k < flen; k++) queue_item(OP_SAMPLE, random_sample(), 1'b0);
        done += flen;
      end else begin
        flen = $urandom_range(6, 1);
        kind = $urandom_range(3, 0);
        for (int k = 0; k < flen; k++) queue_item(OP_SAMPLE, level_sample(kind), k == flen - 1);
        done += flen;
      end
    end
    queue_cmd(OP_STOP);
  endtask

  task automatic wait_idle();
    while (items_to_send.size() != 0 || item_valid || vad_results_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_STEREO_MODE: cur_cfg.stereo_mode = val[0];
      CFG_VAD_ENABLE: cur_cfg.vad_enable = val[0];
      CFG_SPEECH_THRESH: cur_cfg.speech_threshold = val;
      CFG_SILENCE_THRESH: cur_cfg.silence_threshold = val;
      CFG_SPEECH_NEEDED: cur_cfg.speech_frames_needed = val[7:0];
      CFG_SILENCE_NEEDED: cur_cfg.silence_frames_needed = val[7:0];
      default: begin
      end
    endcase
  endtask

  task automatic set_config(input bit st, input bit vd, input logic [15:0] sth,
                            input logic [15:0] slth, input logic [7:0] sn,
                            input logic [7:0] sln);
    write_reg(CFG_STEREO_MODE, {15'd0, st});
    write_reg(CFG_VAD_ENABLE, {15'd0, vd});
    write_reg(CFG_SPEECH_THRESH, sth);
    write_reg(CFG_SILENCE_THRESH, slth);
    write_reg(CFG_SPEECH_NEEDED, {8'd0, sn});
    write_reg(CFG_SILENCE_NEEDED, {8'd0, sln});
  endtask

  task automatic run_phase(input bit st, input bit vd, input logic [15:0] sth,
                           input logic [15:0] slth, input logic [7:0] sn,
                           input logic [7:0] sln, input int n, input bit txg, input bit rxg);
    wait_idle();
    set_config(st, vd, sth, slth, sn, sln);
    tx_gaps_on = txg;
    rx_gaps_on = rxg;
    queue_session(n);
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed part, mono first: ignored items, extreme samples, every frame class.
    set_config(1'b0, 1'b1, 16'd1200, 16'd700, 8'd1, 8'd1);
    write_reg(CFG_BAD_INDEX, 16'hFFFF);
    queue_item(OP_SAMPLE, 16'd100, 1'b1);
    queue_item(OP_UNUSED, 16'hFFFF, 1'b1);
    queue_item(OP_STOP, 16'h0000, 1'b0);
    queue_item(OP_START, 16'h0000, 1'b0);
    queue_item(OP_SAMPLE, 16'h8000, 1'b0);
    queue_item(OP_SAMPLE, 16'h7FFF, 1'b1);
    queue_item(OP_SAMPLE, 16'h0000, 1'b1);
    queue_item(OP_SAMPLE, 16'd1000, 1'b1);
    queue_item(OP_SAMPLE, 16'(-1200), 1'b1);
    queue_item(OP_UNUSED, 16'h1234, 1'b0);
    queue_item(OP_STOP, 16'h0000, 1'b1);
    queue_item(OP_START, 16'h0000, 1'b0);
    queue_item(OP_SAMPLE, 16'd5000, 1'b1);
    queue_item(OP_START, 16'h0000, 1'b1);
    queue_item(OP_SAMPLE, 16'd700, 1'b1);
    queue_item(OP_SAMPLE, 16'd701, 1'b1);
    queue_item(OP_STOP, 16'h0000, 1'b0);
    wait_idle();

    // Stereo: a frame closed on a left sample, then one closed on a right sample.
    write_reg(CFG_STEREO_MODE, 16'd1);
    queue_item(OP_START, 16'h0000, 1'b0);
    queue_item(OP_SAMPLE, 16'd2000, 1'b0);
    queue_item(OP_SAMPLE, 16'h8000, 1'b0);
    queue_item(OP_SAMPLE, 16'd100, 1'b1);
    queue_item(OP_SAMPLE, 16'(-5), 1'b0);
    queue_item(OP_SAMPLE, 16'd30000, 1'b1);
    queue_item(OP_SAMPLE, 16'd3000, 1'b1);
    wait_idle();

    // Detection switched off while speaking: flag frozen, stop gives no event.
    write_reg(CFG_VAD_ENABLE, 16'd0);
    queue_item(OP_SAMPLE, 16'h0000, 1'b0);
    queue_item(OP_SAMPLE, 16'h0000, 1'b1);
    queue_item(OP_STOP, 16'h0000, 1'b0);

    run_phase(1'b0, 1'b1, 16'd1200, 16'd700, 8'd2, 8'd3, 70, 1'b1, 1'b1);
    run_phase(1'b1, 1'b1, 16'd1200, 16'd700, 8'd1, 8'd2, 70, 1'b1, 1'b0);
    run_phase(1'b0, 1'b1, 16'd0, 16'd0, 8'd0, 8'd0, 50, 1'b0, 1'b1);
    run_phase(1'b1, 1'b1, 16'd32768, 16'd32768, 8'd3, 8'd1, 50, 1'b1, 1'b1);
    run_phase(1'b0, 1'b0, 16'($urandom_range(32768, 0)), 16'($urandom_range(32768, 0)),
              8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)), 50, 1'b1, 1'b1);

    // The receiver stalls for a long stretch while items keep coming back to back.
    wait_idle();
    set_config(1'b0, 1'b1, 16'd1200, 16'd700, 8'd2, 8'd3);
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b1;
    hold_req = 1'b1;
    queue_session(40);

    run_phase(1'b1, 1'b1, 16'($urandom_range(32768, 0)), 16'($urandom_range(32768, 0)),
              8'($urandom_range(4, 1)), 8'($urandom_range(4, 1)), 70, 1'b0, 1'b0);

    // Speech count driven past the largest frame count so that it saturates.
    wait_idle();
    set_config(1'b0, 1'b1, 16'd32768, 16'd0, 8'd255, 8'd255);
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    queue_item(OP_START, 16'h0000, 1'b0);
    repeat (258) queue_item(OP_SAMPLE, 16'h8000, 1'b1);
    queue_item(OP_STOP, 16'h0000, 1'b0);

    wait_idle();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && vad_results_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
